>>> design/sphere_collision_pushback_top_defines.svh
// Assertion macros shared by the sphere pushback design.
// Depends on nothing; included by modules that carry assertions.
`ifndef SPHERE_COLLISION_PUSHBACK_TOP_DEFINES_SVH
`define SPHERE_COLLISION_PUSHBACK_TOP_DEFINES_SVH
// Check that a condition implies a consequence on the same edge.
`define SCP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Check that a condition implies a consequence on the next edge.
`define SCP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> design/scp_pkg.sv
// Package for the sphere pushback block: widths, the work item types and a saturation helper.
// Depends on nothing.
package scp_pkg;
  localparam int unsigned CoordW = 32;
  localparam int unsigned RadW = 31;
  localparam int unsigned DiffW = 33;
  localparam int unsigned SqW = 66;
  localparam int unsigned RsW = 32;
  localparam int unsigned DistW = 32;
  localparam int unsigned QDepth = 4;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned NumW = 64;
  localparam int unsigned DivSteps = 64;

  typedef struct packed {
    logic              hit;
    logic [SqW-1:0]    sumsq;
    logic [RsW-1:0]    rs;
    logic [2:0]        neg;
    logic [DiffW-2:0]  mag_x;
    logic [DiffW-2:0]  mag_y;
    logic [DiffW-2:0]  mag_z;
    logic [CoordW-1:0] c1_x;
    logic [CoordW-1:0] c1_y;
    logic [CoordW-1:0] c1_z;
    logic [CoordW-1:0] c2_x;
    logic [CoordW-1:0] c2_y;
    logic [CoordW-1:0] c2_z;
  } item_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } q_ctl_t;

  function automatic logic signed [CoordW-1:0] sat32(input logic signed [DiffW+1:0] v);
    logic signed [DiffW+1:0] mx;
    logic signed [DiffW+1:0] mn;
    mx = (DiffW+2)'(64'sd2147483647);
    mn = (DiffW+2)'(-64'sd2147483648);
    if (v > mx) return 32'sh7fffffff;
    if (v < mn) return 32'sh80000000;
    return v[CoordW-1:0];
  endfunction
endpackage

>>> design/sphere_collision_pushback_top.sv
// Sphere pushback: start passes through 103 register stages to done_o
// (2 front, 1 queue, 33 root, 1 product, 65 divide, 1 output).
// Throughput one request per cycle; busy stays low, results cannot stall.
// Reset is asynchronous active low and clears all valid flags.
module sphere_collision_pushback_top #(
  parameter int unsigned QueueDepth = scp_pkg::QDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  logic signed [31:0] first_center_x_i, first_center_y_i, first_center_z_i,
  input  logic        [30:0] first_radius_i,
  input  logic signed [31:0] second_center_x_i, second_center_y_i, second_center_z_i,
  input  logic        [30:0] second_radius_i,
  output logic done_o,
  output logic hit_o,
  output logic signed [31:0] push_x_o, push_y_o, push_z_o,
  output logic signed [31:0] new_first_x_o, new_first_y_o, new_first_z_o,
  output logic signed [31:0] new_second_x_o, new_second_y_o, new_second_z_o
);
  logic fv;
  scp_pkg::item_t fi, qi, ro;
  scp_pkg::q_ctl_t qc;
  logic [$clog2(QueueDepth+1)-1:0] qcnt;
  logic bv;
  logic [31:0] px, py, pz;

  assign busy = 1'b0;
  scp_front u_front (
    .clk_i, .rst_ni, .in_valid_i(start && !busy),
    .c1x_i(first_center_x_i), .c1y_i(first_center_y_i), .c1z_i(first_center_z_i),
    .r1_i(first_radius_i),
    .c2x_i(second_center_x_i), .c2y_i(second_center_y_i), .c2z_i(second_center_z_i),
    .r2_i(second_radius_i), .out_valid_o(fv), .item_o(fi)
  );
  // Back end never stalls, so drain one entry every cycle it is non-empty.
  always_comb begin
    qc.push = fv;
    qc.empty = (qcnt == '0);
    qc.full = (qcnt == ($clog2(QueueDepth+1))'(QueueDepth));
    qc.pop = !qc.empty;
  end
  scp_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .ctl_i(qc), .wdata_i(fi), .rdata_o(qi), .count_o(qcnt)
  );
  scp_back u_back (
    .clk_i, .rst_ni, .in_valid_i(qc.pop), .item_i(qi),
    .out_valid_o(bv), .res_o(ro), .px_o(px), .py_o(py), .pz_o(pz)
  );
  assign done_o = bv;
  assign hit_o = ro.hit;
  assign push_x_o = px; assign push_y_o = py; assign push_z_o = pz;
  assign new_first_x_o = ro.c1_x; assign new_first_y_o = ro.c1_y;
  assign new_first_z_o = ro.c1_z;
  assign new_second_x_o = ro.c2_x; assign new_second_y_o = ro.c2_y;
  assign new_second_z_o = ro.c2_z;
endmodule

>>> design/scp_front.sv
// Front end: differences, squares and the hit test in two stages.
// Depends on scp_pkg.
module scp_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic signed [scp_pkg::CoordW-1:0] c1x_i, c1y_i, c1z_i,
  input  logic        [scp_pkg::RadW-1:0]   r1_i,
  input  logic signed [scp_pkg::CoordW-1:0] c2x_i, c2y_i, c2z_i,
  input  logic        [scp_pkg::RadW-1:0]   r2_i,
  output logic                         out_valid_o,
  output scp_pkg::item_t               item_o
);
  logic signed [scp_pkg::DiffW-1:0] dx, dy, dz;
  logic [scp_pkg::DiffW-2:0] mx_d, my_d, mz_d, mx_q, my_q, mz_q;
  logic [2:0] neg_d, neg_q;
  logic [scp_pkg::RsW-1:0] rs_d, rs_q;
  logic [scp_pkg::CoordW-1:0] c1x_q, c1y_q, c1z_q, c2x_q, c2y_q, c2z_q;
  logic v1_q, v2_q;
  logic [63:0] sx, sy, sz, rs2;
  logic [scp_pkg::SqW-1:0] sum;
  logic big;
  scp_pkg::item_t item_q;

  assign dx = scp_pkg::DiffW'(c1x_i) - scp_pkg::DiffW'(c2x_i);
  assign dy = scp_pkg::DiffW'(c1y_i) - scp_pkg::DiffW'(c2y_i);
  assign dz = scp_pkg::DiffW'(c1z_i) - scp_pkg::DiffW'(c2z_i);
  always_comb begin
    neg_d = {dz[scp_pkg::DiffW-1], dy[scp_pkg::DiffW-1], dx[scp_pkg::DiffW-1]};
    mx_d = dx[scp_pkg::DiffW-1] ? 32'(-dx) : dx[31:0];
    my_d = dy[scp_pkg::DiffW-1] ? 32'(-dy) : dy[31:0];
    mz_d = dz[scp_pkg::DiffW-1] ? 32'(-dz) : dz[31:0];
    rs_d = {1'b0, r1_i} + {1'b0, r2_i};
  end
  // Magnitude overflow past 32 bits only for -2^32 difference, which cannot occur.
  always_ff @(posedge clk_i) begin
    mx_q <= mx_d; my_q <= my_d; mz_q <= mz_d; neg_q <= neg_d; rs_q <= rs_d;
    c1x_q <= c1x_i; c1y_q <= c1y_i; c1z_q <= c1z_i;
    c2x_q <= c2x_i; c2y_q <= c2y_i; c2z_q <= c2z_i;
  end
  assign sx = 64'(mx_q) * 64'(mx_q);
  assign sy = 64'(my_q) * 64'(my_q);
  assign sz = 64'(mz_q) * 64'(mz_q);
  assign rs2 = 64'(rs_q) * 64'(rs_q);
  assign sum = scp_pkg::SqW'(sx) + scp_pkg::SqW'(sy) + scp_pkg::SqW'(sz);
  assign big = (sum[scp_pkg::SqW-1:64] != '0) || (sum[63:0] > rs2);
  always_ff @(posedge clk_i) begin
    item_q.hit <= !big;
    item_q.sumsq <= sum;
    item_q.rs <= rs_q;
    item_q.neg <= neg_q;
    item_q.mag_x <= mx_q; item_q.mag_y <= my_q; item_q.mag_z <= mz_q;
    item_q.c1_x <= c1x_q; item_q.c1_y <= c1y_q; item_q.c1_z <= c1z_q;
    item_q.c2_x <= c2x_q; item_q.c2_y <= c2y_q; item_q.c2_z <= c2z_q;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i; v2_q <= v1_q;
    end
  end
  assign out_valid_o = v2_q;
  assign item_o = item_q;
endmodule

>>> design/scp_queue.sv
// Short FIFO between front and back ends.
// Depends on scp_pkg.
module scp_queue #(
  parameter int unsigned Depth = scp_pkg::QDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  scp_pkg::q_ctl_t ctl_i,
  input  scp_pkg::item_t  wdata_i,
  output scp_pkg::item_t  rdata_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);
  localparam int unsigned AW = $clog2(Depth);
  scp_pkg::item_t mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [$clog2(Depth+1)-1:0] cnt_q;
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) mem_q[wp_q] <= wdata_i;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (ctl_i.push) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (ctl_i.pop) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + {{($clog2(Depth+1)-1){1'b0}}, ctl_i.push}
                     - {{($clog2(Depth+1)-1){1'b0}}, ctl_i.pop};
    end
  end
  assign rdata_o = mem_q[rp_q];
  assign count_o = cnt_q;
endmodule

>>> design/scp_back.sv
// Back end: pipelined square root, three pipelined dividers, saturation.
// Depends on scp_pkg and the defines header.
`include "sphere_collision_pushback_top_defines.svh"
module scp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  scp_pkg::item_t item_i,
  output logic           out_valid_o,
  output scp_pkg::item_t res_o,
  output logic [scp_pkg::CoordW-1:0] px_o, py_o, pz_o
);
  localparam int unsigned NS = scp_pkg::SqrtSteps;
  localparam int unsigned ND = scp_pkg::DivSteps;
  // Square root: one result bit per stage, restoring.
  logic [NS:0] sv_q;
  scp_pkg::item_t si_q [NS+1];
  logic [63:0] srem_q [NS+1];
  logic [31:0] sroot_q [NS+1];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sv_q <= '0;
    else sv_q <= {sv_q[NS-1:0], in_valid_i};
  end
  always_ff @(posedge clk_i) begin
    si_q[0] <= item_i;
    srem_q[0] <= item_i.sumsq[63:0];
    sroot_q[0] <= '0;
  end
  for (genvar s = 0; s < NS; s++) begin : g_sqrt
    logic [31:0] tr;
    logic [63:0] sq;
    always_comb begin
      tr = sroot_q[s] | (32'd1 << (NS-1-s));
      sq = 64'(tr) * 64'(tr);
    end
    always_ff @(posedge clk_i) begin
      si_q[s+1] <= si_q[s];
      srem_q[s+1] <= srem_q[s];
      sroot_q[s+1] <= (sq <= srem_q[s]) ? tr : sroot_q[s];
    end
  end
  // Products |d|*pen, registered.
  scp_pkg::item_t pi_q;
  logic [31:0] dist_q;
  logic [63:0] nx_q, ny_q, nz_q;
  logic pv_q;
  logic [31:0] pen;
  assign pen = si_q[NS].rs - sroot_q[NS];
  always_ff @(posedge clk_i) begin
    pi_q <= si_q[NS];
    dist_q <= sroot_q[NS];
    nx_q <= 64'(si_q[NS].mag_x) * 64'(pen);
    ny_q <= 64'(si_q[NS].mag_y) * 64'(pen);
    nz_q <= 64'(si_q[NS].mag_z) * 64'(pen);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pv_q <= 1'b0;
    else pv_q <= sv_q[NS];
  end
  // Division: one quotient bit per stage over three lanes.
  logic [ND:0] dv_q;
  scp_pkg::item_t di_q [ND+1];
  logic [31:0] dd_q [ND+1];
  logic [63:0] dq_q [ND+1][3];
  logic [32:0] dr_q [ND+1][3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_q <= '0;
    else dv_q <= {dv_q[ND-1:0], pv_q};
  end
  always_ff @(posedge clk_i) begin
    di_q[0] <= pi_q; dd_q[0] <= dist_q;
    dq_q[0][0] <= nx_q; dq_q[0][1] <= ny_q; dq_q[0][2] <= nz_q;
    for (int l = 0; l < 3; l++) dr_q[0][l] <= '0;
  end
  for (genvar s = 0; s < ND; s++) begin : g_div
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [33:0] t;
      logic [33:0] sub;
      always_comb begin
        t = {dr_q[s][l], dq_q[s][l][63]};
        sub = t - {2'b0, dd_q[s]};
      end
      always_ff @(posedge clk_i) begin
        dr_q[s+1][l] <= sub[33] ? t[32:0] : sub[32:0];
        dq_q[s+1][l] <= {dq_q[s][l][62:0], ~sub[33]};
      end
    end
    always_ff @(posedge clk_i) begin
      di_q[s+1] <= di_q[s]; dd_q[s+1] <= dd_q[s];
    end
  end
  // Sign, saturate and form new centers.
  logic signed [scp_pkg::CoordW-1:0] p [3];
  logic signed [scp_pkg::CoordW-1:0] c1 [3];
  logic signed [scp_pkg::CoordW-1:0] c2 [3];
  logic signed [scp_pkg::CoordW-1:0] n1 [3];
  logic signed [scp_pkg::CoordW-1:0] n2 [3];
  scp_pkg::item_t it;
  scp_pkg::item_t ro_d;
  always_comb begin
    it = di_q[ND];
    c1[0] = it.c1_x; c1[1] = it.c1_y; c1[2] = it.c1_z;
    c2[0] = it.c2_x; c2[1] = it.c2_y; c2[2] = it.c2_z;
    for (int l = 0; l < 3; l++) begin
      if (!it.hit || dd_q[ND] == '0) p[l] = '0;
      else if (dq_q[ND][l] > 64'h7fffffff) p[l] = it.neg[l] ? 32'sh80000000 : 32'sh7fffffff;
      else p[l] = it.neg[l] ? -$signed(dq_q[ND][l][31:0]) : $signed(dq_q[ND][l][31:0]);
      if (it.neg[l] && dq_q[ND][l] == 64'h80000000 && it.hit && dd_q[ND] != '0)
        p[l] = 32'sh80000000;
      n1[l] = scp_pkg::sat32(35'(c1[l]) + 35'(p[l]));
      n2[l] = scp_pkg::sat32(35'(c2[l]) - 35'(p[l]));
    end
    ro_d = it;
    ro_d.c1_x = n1[0]; ro_d.c1_y = n1[1]; ro_d.c1_z = n1[2];
    ro_d.c2_x = n2[0]; ro_d.c2_y = n2[1]; ro_d.c2_z = n2[2];
  end
  logic ov_q;
  scp_pkg::item_t ro_q;
  logic [scp_pkg::CoordW-1:0] px_q, py_q, pz_q;
  always_ff @(posedge clk_i) begin
    ro_q <= ro_d;
    px_q <= p[0]; py_q <= p[1]; pz_q <= p[2];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else ov_q <= dv_q[ND];
  end
  assign out_valid_o = ov_q;
  assign res_o = ro_q;
  assign px_o = px_q; assign py_o = py_q; assign pz_o = pz_q;

  `SCP_ASSERT_NEXT(a_sqrt_to_prod, clk_i, rst_ni, sv_q[NS], pv_q)
  `SCP_ASSERT_NEXT(a_div_to_out, clk_i, rst_ni, dv_q[ND], ov_q)
  `SCP_ASSERT_IMP(a_nohit_zero, clk_i, rst_ni, ov_q && !ro_q.hit, px_q == '0 && py_q == '0 && pz_q == '0)
endmodule
